>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/dbe_pkg.sv
// ----------------------------------------------------------------------------
// Dihedral bending energy package
// Shared types and constants for the front end, queue and compute engine.
// ----------------------------------------------------------------------------
package dbe_pkg;

  localparam int unsigned ONE_Q16  = 65536;
  localparam int unsigned DIFF_W   = 33;
  localparam int unsigned SUM_W    = 48;

  // One complete dihedral as handed from the front end to the engine.
  typedef struct packed {
    logic signed [2:0][DIFF_W-1:0] cb;
    logic signed [2:0][DIFF_W-1:0] ab;
    logic signed [2:0][DIFF_W-1:0] dc;
    logic                          last;
  } job_t;

  typedef enum logic [3:0] {
    EN_IDLE,
    EN_RED1,
    EN_CROSS,
    EN_RED2,
    EN_DOT,
    EN_PROD,
    EN_SQRT,
    EN_DIV,
    EN_ENERGY,
    EN_OUT
  } eng_state_t;

  // Shift needed so every magnitude drops below 2^lim_bits (magnitudes < 2^64).
  function automatic logic [5:0] red_shift(input logic [63:0] m, input int lim_bits);
    logic [5:0] k;
    k = '0;
    for (int i = 63; i >= 0; i--) begin
      if (m[i] && (i >= lim_bits) && (k == '0)) begin
        k = 6'(i - lim_bits + 1);
      end
    end
    return k;
  endfunction

endpackage

>>> rtl/core/dbe_front.sv
// ----------------------------------------------------------------------------
// Dihedral front end
// Collects four vertices and forms the three difference vectors as a job.
// ----------------------------------------------------------------------------
module dbe_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic signed [31:0]  coord_z,
  input  logic                last_dihedral,
  output logic                job_valid,
  input  logic                job_ready,
  output dbe_pkg::job_t       job
);
  import dbe_pkg::*;

  logic [2:0][2:0][31:0] held;
  logic [1:0]            vertex_count;
  logic                  fourth;
  logic [2:0][31:0]      d;

  assign fourth    = (vertex_count == 2'd3);
  assign in_ready  = !fourth || job_ready;
  assign job_valid = in_valid && fourth;
  assign d[0] = coord_x;
  assign d[1] = coord_y;
  assign d[2] = coord_z;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      job.cb[j] = {held[2][j][31], held[2][j]} - {held[1][j][31], held[1][j]};
      job.ab[j] = {held[0][j][31], held[0][j]} - {held[1][j][31], held[1][j]};
      job.dc[j] = {d[j][31], d[j]} - {held[2][j][31], held[2][j]};
    end
    job.last = last_dihedral;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      held         <= '0;
    end else if (in_valid && in_ready) begin
      vertex_count <= vertex_count + 2'd1;
      if (!fourth) begin
        held[vertex_count] <= d;
      end
    end
  end

endmodule

>>> rtl/core/dbe_queue.sv
// ----------------------------------------------------------------------------
// Dihedral job queue
// Two-entry FIFO between front end and engine.
// ----------------------------------------------------------------------------
module dbe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  dbe_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output dbe_pkg::job_t rd_data
);
  import dbe_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

>>> rtl/core/dbe_engine.sv
// ----------------------------------------------------------------------------
// Dihedral energy engine
// Reduces, crosses, takes an iterative root and divide, forms the energy.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dbe_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   kappa,
  input  logic          job_valid,
  output logic          job_ready,
  input  dbe_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   energy,
  output logic [47:0]   total,
  output logic          degen,
  output logic          done
);
  import dbe_pkg::*;

  eng_state_t state;
  eng_state_t state_next;

  logic signed [2:0][31:0] cb, ab, dc;
  logic signed [2:0][63:0] na, nb;
  logic signed [2:0][15:0] ra, rb;
  logic                    last;
  logic signed [33:0]      dot;
  logic [31:0]             sa, sb;
  logic [63:0]             sq_n, sq_res, sq_bit;
  logic [48:0]             dv_rem;
  logic [47:0]             dv_num;
  logic [16:0]             dv_q;
  logic [5:0]              step;
  logic [47:0]             sum;
  logic [32:0]             cos_term;

  // Magnitude reduction of a 3-vector
  function automatic logic [2:0][63:0] reduce(input logic [2:0][63:0] v, input int lim);
    logic [2:0][63:0] m, r;
    logic [63:0] mx;
    logic [5:0]  k;
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i][63] ? 64'(-v[i]) : v[i];
      if (m[i] > mx) mx = m[i];
    end
    k = red_shift(mx, lim);
    for (int i = 0; i < 3; i++) begin
      r[i] = m[i] >> k;
      r[i] = v[i][63] ? 64'(-r[i]) : r[i];
    end
    return r;
  endfunction

  // Signed 32 x 32 product
  function automatic logic signed [63:0] smul32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p;
  endfunction

  // Signed 16 x 16 product
  function automatic logic signed [31:0] smul16(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
    logic signed [31:0] p;
    p = a * b;
    return p;
  endfunction

  logic [2:0][63:0] ext_cb, ext_ab, ext_dc, red_cb, red_ab, red_dc, red_na, red_nb;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext_cb[i] = 64'(signed'(job.cb[i]));
      ext_ab[i] = 64'(signed'(job.ab[i]));
      ext_dc[i] = 64'(signed'(job.dc[i]));
    end
    red_cb = reduce(ext_cb, 30);
    red_ab = reduce(ext_ab, 30);
    red_dc = reduce(ext_dc, 30);
    red_na = reduce(na, 15);
    red_nb = reduce(nb, 15);
  end

  logic [63:0] sq_try;
  logic [48:0] dv_t;
  logic [63:0] energy_prod;
  logic [31:0] energy_new;
  assign sq_try   = sq_res + sq_bit;
  assign dv_t     = {dv_rem[47:0], dv_num[step]};
  assign cos_term = degen ? 33'(ONE_Q16)
                  : (dot[33] ? 33'(ONE_Q16) - 33'(dv_q) : 33'(ONE_Q16) + 33'(dv_q));
  assign energy_prod = kappa * cos_term;
  assign energy_new  = energy_prod[48:17];
  assign job_ready = (state == EN_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      EN_IDLE:   if (job_valid) state_next = EN_CROSS;
      EN_RED1:   state_next = EN_CROSS;
      EN_CROSS:  state_next = EN_RED2;
      EN_RED2:   state_next = EN_DOT;
      EN_DOT:    state_next = EN_PROD;
      EN_PROD:   state_next = EN_SQRT;
      EN_SQRT:   if (step == 6'd0) state_next = EN_DIV;
      EN_DIV:    if (step == 6'd0) state_next = EN_ENERGY;
      EN_ENERGY: state_next = EN_OUT;
      EN_OUT:    if (out_ready) state_next = EN_IDLE;
      default:   state_next = EN_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (state == EN_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EN_IDLE;
      sum   <= '0;
    end else begin
      state <= state_next;
      if (state == EN_ENERGY) begin
        sum <= (49'(sum) + 49'(energy_new) > 49'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF
                                                                : sum + 48'(energy_new);
      end
      if (state == EN_OUT && out_ready && last) sum <= '0;
    end
  end

  assign total = sum;

  always_ff @(posedge clk) begin
    case (state)
      EN_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          cb[i] <= 32'(red_cb[i]);
          ab[i] <= 32'(red_ab[i]);
          dc[i] <= 32'(red_dc[i]);
        end
        last <= job.last;
      end
      EN_CROSS: begin
        na[0] <= smul32(cb[1], ab[2]) - smul32(cb[2], ab[1]);
        na[1] <= smul32(cb[2], ab[0]) - smul32(cb[0], ab[2]);
        na[2] <= smul32(cb[0], ab[1]) - smul32(cb[1], ab[0]);
        nb[0] <= smul32(cb[1], dc[2]) - smul32(cb[2], dc[1]);
        nb[1] <= smul32(cb[2], dc[0]) - smul32(cb[0], dc[2]);
        nb[2] <= smul32(cb[0], dc[1]) - smul32(cb[1], dc[0]);
      end
      EN_RED2: begin
        for (int i = 0; i < 3; i++) begin
          ra[i] <= 16'(red_na[i]);
          rb[i] <= 16'(red_nb[i]);
        end
      end
      EN_DOT: begin
        dot <= 34'(smul16(ra[0], rb[0])) + 34'(smul16(ra[1], rb[1]))
             + 34'(smul16(ra[2], rb[2]));
        sa  <= 32'(smul16(ra[0], ra[0])) + 32'(smul16(ra[1], ra[1]))
             + 32'(smul16(ra[2], ra[2]));
        sb  <= 32'(smul16(rb[0], rb[0])) + 32'(smul16(rb[1], rb[1]))
             + 32'(smul16(rb[2], rb[2]));
      end
      EN_PROD: begin
        sq_n   <= 64'(sa) * 64'(sb);
        sq_res <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
        step   <= 6'd31;
        degen  <= (sa == '0) || (sb == '0);
        dv_num <= {32'(dot[33] ? -dot : dot), 16'h0};
      end
      EN_SQRT: begin
        // one root digit per cycle
        if (sq_n >= sq_try) begin
          sq_n   <= sq_n - sq_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (step == 6'd0) begin
          dv_rem <= '0;
          dv_q   <= '0;
          step   <= 6'd47;
        end else begin
          step <= step - 6'd1;
        end
      end
      EN_DIV: begin
        // restoring divide, one quotient bit per cycle, saturate at one
        if (!degen && dv_t >= 49'(sq_res)) begin
          dv_rem <= dv_t - 49'(sq_res);
          dv_q   <= (dv_q >= 17'(ONE_Q16)) ? 17'(ONE_Q16)
                  : (dv_q[15:0] == 16'hFFFF && dv_q[16] == 1'b0) ? 17'(ONE_Q16)
                  : {dv_q[15:0], 1'b1};
        end else begin
          dv_rem <= dv_t;
          dv_q   <= (dv_q >= 17'(ONE_Q16)) ? 17'(ONE_Q16)
                  : (dv_q[16]) ? 17'(ONE_Q16) : {dv_q[15:0], 1'b0};
        end
        if (step != 6'd0) step <= step - 6'd1;
      end
      EN_ENERGY: begin
        energy <= energy_new;
      end
      EN_OUT: begin
        done <= last;
      end
      default: begin
      end
    endcase
    if (state == EN_ENERGY) done <= last;
  end

  `ASSERT_IMPL(a_out_hold, clk, rst, out_valid && !out_ready, state_next == EN_OUT, "result dropped while stalled")
  `ASSERT_NEXT(a_take_job, clk, rst, job_valid && job_ready, state == EN_CROSS, "job not started")
  `ASSERT_IMPL(a_busy, clk, rst, state != EN_IDLE, !job_ready, "job taken while busy")

endmodule

>>> rtl/core/dihedral_bending_energy_top.sv
// ----------------------------------------------------------------------------
// Dihedral bending energy top level
// Front end, job queue and compute engine with the stiffness register.
// ----------------------------------------------------------------------------
// Usage:
//   Vertices a, b, c, d of a dihedral enter one per item on the in channel
//   (in_valid/in_ready). Every fourth vertex produces one result on the out
//   channel (out_valid/out_ready): energy, saturating running total,
//   degenerate flag and frame_done. last_dihedral on the fourth vertex ends
//   the frame and clears the total after that result.
//   The stiffness register is written through cfg_valid/cfg_ready/cfg_data;
//   the user must write it only while the block is idle; the block itself
//   does not enforce this. It resets to 1.0 in Q16.16. The engine forms each
//   result with a 32-step square root and a 48-step divide. A two-entry job
//   queue lets the front end keep taking vertices while the engine works;
//   the engine takes a new dihedral only once the last result has been taken.
//   Reset clears held vertices, the count, the total and the queue.
//   A stalled receiver holds the result; the queue then fills and the front
//   end stops taking the fourth vertex of the next dihedral.
// ----------------------------------------------------------------------------
module dihedral_bending_energy_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic               last_dihedral,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        dihedral_energy,
  output logic [47:0]        energy_total,
  output logic               degenerate,
  output logic               frame_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import dbe_pkg::*;

  logic [31:0] bending_stiffness;
  logic        f_valid, f_ready, q_valid, q_ready;
  job_t        f_job, q_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bending_stiffness <= 32'(ONE_Q16);
    end else if (cfg_valid) begin
      bending_stiffness <= cfg_data;
    end
  end

  dbe_front u_front (
    .clk, .rst, .in_valid, .in_ready, .coord_x, .coord_y, .coord_z, .last_dihedral,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  dbe_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
  );

  dbe_engine u_engine (
    .clk, .rst, .kappa(bending_stiffness),
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_valid, .out_ready, .energy(dihedral_energy), .total(energy_total),
    .degen(degenerate), .done(frame_done)
  );

endmodule
